### rtl/core/normal_quantile_approx_macros.svh
// Assertion macros shared by the normal quantile approximation RTL.
`ifndef NORMAL_QUANTILE_APPROX_MACROS_SVH
`define NORMAL_QUANTILE_APPROX_MACROS_SVH

// cons must hold in the same cycle as ante
`define NQA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define NQA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/nqa_pkg.sv
// Shared types and constants for the normal quantile approximation block.
package nqa_pkg;

  // internal fixed point: unsigned, 32 fraction bits
  localparam int FRAC_BITS  = 32;
  localparam int DW         = 40;
  localparam int SHIFT_W    = 6;
  localparam int MAG_W      = 49;
  localparam int OUT_W      = 32;
  localparam int LOG_STEPS  = 32;
  localparam int SQRT_STEPS = 36;
  localparam int DIV_STEPS  = 40;
  localparam int QDEPTH     = 2;

  localparam logic [DW-1:0] TWO_LN2 = 40'd5954088944;
  localparam logic [DW-1:0] ONE     = 40'h01_0000_0000;

  // rational approximation coefficients, round(c * 2^32)
  localparam logic [DW-1:0] C0 = DW'(((64'd2515517 << 32) + 64'd500000) / 64'd1000000);
  localparam logic [DW-1:0] C1 = DW'(((64'd802853 << 32) + 64'd500000) / 64'd1000000);
  localparam logic [DW-1:0] C2 = DW'(((64'd10328 << 32) + 64'd500000) / 64'd1000000);
  localparam logic [DW-1:0] D1 = DW'(((64'd1432788 << 32) + 64'd500000) / 64'd1000000);
  localparam logic [DW-1:0] D2 = DW'(((64'd189269 << 32) + 64'd500000) / 64'd1000000);
  localparam logic [DW-1:0] D3 = DW'(((64'd1308 << 32) + 64'd500000) / 64'd1000000);

  // output saturation limits
  localparam logic [OUT_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [OUT_W-1:0] Q_MAX = 32'h7FFF_FFFF;

  // item classification carried beside the tail probability
  typedef struct packed {
    logic zero;
    logic upper;
  } tag_t;

endpackage

### rtl/core/normal_quantile_approx.sv
// Top level of the normal quantile approximation block.
// Returns the approximate standard normal quantile of a probability given as an
// unsigned fraction (probability / 2^PROB_BITS), as a signed value with OUT_FRAC_BITS
// fraction bits, using the rational formula 26.2.23 of the classic handbook. A zero
// probability sets out_of_range and gives the most negative quantile. The block takes
// one beat per clock while neither side stalls and gives one result per beat in order.
// The pipelined units set its depth: 32 squaring stages for log2, 36 square-root
// stages and 40 divider stages, with the front register, a two-entry queue and the
// output register around them.
module normal_quantile_approx #(
  parameter int PROB_BITS     = 32,
  parameter int OUT_FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PROB_BITS-1:0] probability,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   quantile,
  output logic                 out_of_range
);

  localparam int QW = PROB_BITS + 2;

  logic                 f_valid;
  logic                 f_stall;
  logic [PROB_BITS-1:0] f_t;
  nqa_pkg::tag_t        f_tag;
  logic                 q_valid;
  logic                 q_pop;
  logic [QW-1:0]        q_data;
  nqa_pkg::tag_t        q_tag;

  nqa_front #(
    .PROB_BITS (PROB_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .probability (probability),
    .item_valid  (f_valid),
    .item_stall  (f_stall),
    .item_t      (f_t),
    .item_tag    (f_tag)
  );

  nqa_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_data  ({f_tag, f_t}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  assign q_tag = nqa_pkg::tag_t'(q_data[QW-1:PROB_BITS]);

  nqa_back #(
    .PROB_BITS     (PROB_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (q_valid),
    .item_t       (q_data[PROB_BITS-1:0]),
    .item_tag     (q_tag),
    .item_pop     (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .quantile     (quantile),
    .out_of_range (out_of_range)
  );

endmodule

### rtl/core/nqa_front.sv
// Front end: takes input beats, folds the probability to its tail and classifies it.
module nqa_front #(
  parameter int PROB_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PROB_BITS-1:0] probability,
  output logic                 item_valid,
  input  logic                 item_stall,
  output logic [PROB_BITS-1:0] item_t,
  output nqa_pkg::tag_t        item_tag
);

  localparam logic [PROB_BITS-1:0] HALF = {1'b1, {(PROB_BITS-1){1'b0}}};

  logic                 zero;
  logic                 upper;
  logic [PROB_BITS-1:0] t_sel;

  // fold: t = p or 1 - p; a zero probability runs through with t set to one LSB
  always_comb begin
    zero  = (probability == '0);
    upper = (probability > HALF);
    if (zero) begin
      t_sel = PROB_BITS'(1);
    end else if (upper) begin
      t_sel = '0 - probability;
    end else begin
      t_sel = probability;
    end
  end

  assign in_stall = item_valid && item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_t         <= t_sel;
      item_tag.zero  <= zero;
      item_tag.upper <= upper;
    end
  end

endmodule

### rtl/core/nqa_queue.sv
// Short queue between the front end and the arithmetic back end.
`include "normal_quantile_approx_macros.svh"

module nqa_queue #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_stall,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = nqa_pkg::QDEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;

  assign push_stall = (count == CW'(DEPTH));
  assign push       = push_valid && !push_stall;
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `NQA_ASSERT_SAME(a_pop_nonempty, pop, count != '0, "queue popped while empty")
  `NQA_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count missed a push")
  `NQA_ASSERT_NEXT(a_count_dn, pop && !push, count == $past(count) - 1'b1, "count missed a pop")

endmodule

### rtl/core/nqa_qmul.sv
// Two-stage fixed point multiply: p = floor(a * b / 2^32) from four partial products.
module nqa_qmul (
  input  logic                   clk,
  input  logic                   en,
  input  logic [nqa_pkg::DW-1:0] a,
  input  logic [nqa_pkg::DW-1:0] b,
  output logic [nqa_pkg::DW-1:0] p
);

  localparam int DW = nqa_pkg::DW;
  localparam int HW = DW - 32;

  logic [2*HW-1:0] pp_hh;
  logic [DW-1:0]   pp_hl;
  logic [DW-1:0]   pp_lh;
  logic [31:0]     pp_ll;
  logic [63:0]     ll_full;
  logic [47:0]     sum;

  assign ll_full = 64'(a[31:0]) * 64'(b[31:0]);

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= a[DW-1:32] * b[DW-1:32];
      pp_hl <= DW'(a[DW-1:32]) * DW'(b[31:0]);
      pp_lh <= DW'(a[31:0]) * DW'(b[DW-1:32]);
      pp_ll <= ll_full[63:32];
    end
  end

  // stage 2: weighted sum
  assign sum = (48'(pp_hh) << 32) + 48'(pp_hl) + 48'(pp_lh) + 48'(pp_ll);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum[DW-1:0];
    end
  end

endmodule

### rtl/core/nqa_back.sv
// Back end: pipelined log2, square root, rational term, divide and output conversion.
`include "normal_quantile_approx_macros.svh"

module nqa_back #(
  parameter int PROB_BITS     = 32,
  parameter int OUT_FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic [PROB_BITS-1:0] item_t,
  input  nqa_pkg::tag_t        item_tag,
  output logic                 item_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   quantile,
  output logic                 out_of_range
);

  localparam int DW     = nqa_pkg::DW;
  localparam int SW     = nqa_pkg::SHIFT_W;
  localparam int MW     = nqa_pkg::MAG_W;
  localparam int NLOG   = nqa_pkg::LOG_STEPS;
  localparam int NSQ    = nqa_pkg::SQRT_STEPS;
  localparam int NDIV   = nqa_pkg::DIV_STEPS;
  localparam int RW     = DW + 1;
  localparam int NS     = $clog2(PROB_BITS);
  localparam int L_NORM = NS;
  localparam int L_LOG  = L_NORM + NLOG;
  localparam int L_LF   = L_LOG + 1;
  localparam int L_Y    = L_LF + 2;
  localparam int L_SQ   = L_Y + NSQ;
  localparam int L_POLY = L_SQ + 9;
  localparam int L_DIV  = L_POLY + NDIV;
  localparam int TOT    = L_DIV + 2;

  logic en;

  // whole pipeline advances unless a result is held at the output
  assign en       = !(out_valid && out_stall);
  assign item_pop = en && item_valid;

  // valid and tag chain
  logic [TOT-1:0] vld;
  nqa_pkg::tag_t  tag [TOT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= item_tag;
      for (int i = 1; i < TOT; i++) begin
        tag[i] <= tag[i-1];
      end
    end
  end

  // normalize: shift the leading one to the top, count the shift
  logic [PROB_BITS-1:0] nv      [NS];
  logic [PROB_BITS-1:0] nv_in   [NS];
  logic [PROB_BITS-1:0] nv_next [NS];
  logic [SW-1:0]        nc      [NS];
  logic [SW-1:0]        nc_in   [NS];
  logic [SW-1:0]        nc_next [NS];

  always_comb begin
    nv_in[0] = item_t;
    nc_in[0] = '0;
    for (int j = 1; j < NS; j++) begin
      nv_in[j] = nv[j-1];
      nc_in[j] = nc[j-1];
    end
    for (int j = 0; j < NS; j++) begin
      if ((nv_in[j] >> (PROB_BITS - (1 << (NS - 1 - j)))) == '0) begin
        nv_next[j] = nv_in[j] << (1 << (NS - 1 - j));
        nc_next[j] = nc_in[j] + SW'(1 << (NS - 1 - j));
      end else begin
        nv_next[j] = nv_in[j];
        nc_next[j] = nc_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nv <= nv_next;
      nc <= nc_next;
    end
  end

  // mantissa in Q1.31
  logic [31:0] mant;

  generate
    if (PROB_BITS >= 32) begin : g_mant_hi
      assign mant = nv[NS-1][PROB_BITS-1 -: 32];
    end else begin : g_mant_lo
      assign mant = {nv[NS-1], {(32 - PROB_BITS){1'b0}}};
    end
  endgenerate

  // log2 fraction bits, one squaring per stage
  logic [31:0]   lm      [NLOG];
  logic [31:0]   lm_in   [NLOG];
  logic [31:0]   lm_next [NLOG];
  logic [31:0]   lf      [NLOG];
  logic [31:0]   lf_in   [NLOG];
  logic [31:0]   lf_next [NLOG];
  logic [SW-1:0] ls      [NLOG];
  logic [SW-1:0] ls_in   [NLOG];

  always_comb begin
    logic [63:0] sq;
    logic [32:0] x;
    lm_in[0] = mant;
    lf_in[0] = '0;
    ls_in[0] = nc[NS-1];
    for (int j = 1; j < NLOG; j++) begin
      lm_in[j] = lm[j-1];
      lf_in[j] = lf[j-1];
      ls_in[j] = ls[j-1];
    end
    for (int j = 0; j < NLOG; j++) begin
      sq = 64'(lm_in[j]) * 64'(lm_in[j]);
      x  = sq[63:31];
      if (x[32]) begin
        lm_next[j] = x[32:1];
        lf_next[j] = {lf_in[j][30:0], 1'b1};
      end else begin
        lm_next[j] = x[31:0];
        lf_next[j] = {lf_in[j][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lm <= lm_next;
      lf <= lf_next;
      ls <= ls_in;
    end
  end

  // -log2(t) in Q.32: shift count plus one, less the fraction
  logic [DW-1:0] lval;

  always_ff @(posedge clk) begin
    if (en) begin
      lval <= ((DW'(ls[NLOG-1]) + DW'(1)) << 32) - DW'(lf[NLOG-1]);
    end
  end

  // y = -2 ln t
  logic [DW-1:0] yv;

  nqa_qmul u_ymul (
    .clk (clk),
    .en  (en),
    .a   (lval),
    .b   (nqa_pkg::TWO_LN2),
    .p   (yv)
  );

  // square root, one result bit per stage
  logic [DW-1:0]  sy      [NSQ];
  logic [DW-1:0]  sy_in   [NSQ];
  logic [RW-1:0]  sr      [NSQ];
  logic [RW-1:0]  sr_in   [NSQ];
  logic [RW-1:0]  sr_next [NSQ];
  logic [NSQ-1:0] so      [NSQ];
  logic [NSQ-1:0] so_in   [NSQ];
  logic [NSQ-1:0] so_next [NSQ];

  always_comb begin
    int          i;
    logic [1:0]  pair;
    logic [RW-1:0] r2;
    logic [RW-1:0] trial;
    sy_in[0] = yv;
    sr_in[0] = '0;
    so_in[0] = '0;
    for (int j = 1; j < NSQ; j++) begin
      sy_in[j] = sy[j-1];
      sr_in[j] = sr[j-1];
      so_in[j] = so[j-1];
    end
    for (int j = 0; j < NSQ; j++) begin
      i = NSQ - 1 - j;
      if (i >= 16) begin
        pair = 2'(sy_in[j] >> (2 * i - 32));
      end else begin
        pair = 2'b00;
      end
      r2    = {sr_in[j][RW-3:0], pair};
      trial = (RW'(so_in[j]) << 2) | RW'(1);
      if (r2 >= trial) begin
        sr_next[j] = r2 - trial;
        so_next[j] = {so_in[j][NSQ-2:0], 1'b1};
      end else begin
        sr_next[j] = r2;
        so_next[j] = {so_in[j][NSQ-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sy <= sy_in;
      sr <= sr_next;
      so <= so_next;
    end
  end

  // rational term: numerator and denominator by Horner steps
  logic [DW-1:0] eta_w;
  logic [DW-1:0] eta_p [9];
  logic [DW-1:0] a1;
  logic [DW-1:0] b1;
  logic [DW-1:0] x1;
  logic [DW-1:0] y1;
  logic [DW-1:0] a2;
  logic [DW-1:0] b2;
  logic [DW-1:0] num5;
  logic [DW-1:0] y2;
  logic [DW-1:0] b3;
  logic [DW-1:0] num6;
  logic [DW-1:0] num7;
  logic [DW-1:0] num8;
  logic [DW-1:0] den8;

  assign eta_w = DW'(so[NSQ-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      eta_p[0] <= eta_w;
      for (int k = 1; k < 9; k++) begin
        eta_p[k] <= eta_p[k-1];
      end
    end
  end

  nqa_qmul u_r1a (.clk(clk), .en(en), .a(nqa_pkg::C2), .b(eta_w), .p(a1));
  nqa_qmul u_r1b (.clk(clk), .en(en), .a(nqa_pkg::D3), .b(eta_w), .p(b1));

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= a1 + nqa_pkg::C1;
      y1 <= b1 + nqa_pkg::D2;
    end
  end

  nqa_qmul u_r2a (.clk(clk), .en(en), .a(x1), .b(eta_p[2]), .p(a2));
  nqa_qmul u_r2b (.clk(clk), .en(en), .a(y1), .b(eta_p[2]), .p(b2));

  always_ff @(posedge clk) begin
    if (en) begin
      num5 <= a2 + nqa_pkg::C0;
      y2   <= b2 + nqa_pkg::D1;
    end
  end

  nqa_qmul u_r3b (.clk(clk), .en(en), .a(y2), .b(eta_p[5]), .p(b3));

  always_ff @(posedge clk) begin
    if (en) begin
      num6 <= num5;
      num7 <= num6;
      num8 <= num7;
      den8 <= b3 + nqa_pkg::ONE;
    end
  end

  // restoring divide, one quotient bit per stage: term = num * 2^32 / den
  logic [DW-1:0] dr      [NDIV];
  logic [DW-1:0] dr_in   [NDIV];
  logic [DW-1:0] dr_next [NDIV];
  logic [DW-1:0] dq      [NDIV];
  logic [DW-1:0] dq_in   [NDIV];
  logic [DW-1:0] dq_next [NDIV];
  logic [DW-1:0] dd      [NDIV];
  logic [DW-1:0] dd_in   [NDIV];
  logic [7:0]    dn      [NDIV];
  logic [7:0]    dn_in   [NDIV];
  logic [DW-1:0] de      [NDIV];
  logic [DW-1:0] de_in   [NDIV];

  always_comb begin
    logic          nbit;
    logic [RW-1:0] r2;
    dr_in[0] = num8 >> 8;
    dq_in[0] = '0;
    dd_in[0] = den8;
    dn_in[0] = num8[7:0];
    de_in[0] = eta_p[8];
    for (int j = 1; j < NDIV; j++) begin
      dr_in[j] = dr[j-1];
      dq_in[j] = dq[j-1];
      dd_in[j] = dd[j-1];
      dn_in[j] = dn[j-1];
      de_in[j] = de[j-1];
    end
    for (int j = 0; j < NDIV; j++) begin
      if (j < 8) begin
        nbit = dn_in[j][7 - j];
      end else begin
        nbit = 1'b0;
      end
      r2 = {dr_in[j], nbit};
      if (r2 >= {1'b0, dd_in[j]}) begin
        dr_next[j] = DW'(r2 - {1'b0, dd_in[j]});
        dq_next[j] = {dq_in[j][DW-2:0], 1'b1};
      end else begin
        dr_next[j] = r2[DW-1:0];
        dq_next[j] = {dq_in[j][DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr <= dr_next;
      dq <= dq_next;
      dd <= dd_in;
      dn <= dn_in;
      de <= de_in;
    end
  end

  // sign, magnitude and scaling to the output format
  logic [DW-1:0] term;
  logic [DW-1:0] eta_f;
  logic [DW-1:0] adiff;
  logic          neg;
  logic [MW-1:0] mag_w;
  logic [MW-1:0] mag_sc;
  logic [MW-1:0] fmag;
  logic          fneg;

  assign term  = dq[NDIV-1];
  assign eta_f = de[NDIV-1];

  always_comb begin
    if (eta_f > term) begin
      adiff = eta_f - term;
    end else begin
      adiff = term - eta_f;
    end
    neg = tag[L_DIV-1].upper ? (term > eta_f) : (eta_f > term);
  end

  assign mag_w = MW'(adiff);

  generate
    if (OUT_FRAC_BITS < 32) begin : g_round
      localparam int S = 32 - OUT_FRAC_BITS;
      assign mag_sc = (mag_w + (MW'(1) << (S - 1))) >> S;
    end else begin : g_shift
      assign mag_sc = mag_w << (OUT_FRAC_BITS - 32);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      fmag <= mag_sc;
      fneg <= neg;
    end
  end

  // saturate to 32 bits
  logic [MW-1:0] fmag_neg;
  logic [31:0]   qsat;
  logic [31:0]   qv;

  assign fmag_neg = '0 - fmag;

  always_comb begin
    if (fneg) begin
      if (fmag > MW'(nqa_pkg::Q_MIN)) begin
        qsat = nqa_pkg::Q_MIN;
      end else begin
        qsat = fmag_neg[31:0];
      end
    end else begin
      if (fmag > MW'(nqa_pkg::Q_MAX)) begin
        qsat = nqa_pkg::Q_MAX;
      end else begin
        qsat = fmag[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qv <= qsat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[TOT-1]) begin
      quantile     <= tag[TOT-1].zero ? nqa_pkg::Q_MIN : qv;
      out_of_range <= tag[TOT-1].zero;
    end
  end

  `NQA_ASSERT_SAME(a_oor_sat, out_valid && out_of_range, quantile == nqa_pkg::Q_MIN, "zero probability not saturated")

endmodule
